>>> hdl/tpfm_pkg.sv
// Shared types, widths, register indexes and codes of the pulse frequency meter.
// Used by the core, the divider and the port checker. Depends on nothing.
package tpfm_pkg;

   localparam int MAX_SAMPLES_DEF   = 16;
   localparam int INTERVAL_BITS_DEF = 24;

   // Configuration register widths and the configuration port.
   localparam int LEN_W      = 5;
   localparam int TPS_BITS   = 20;
   localparam int FREQ_BITS  = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Q16.8 result: the numerator carries eight fraction bits.
   localparam int FRAC_BITS = 8;

   localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_SEC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIM   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIM  = 2'd3;

   localparam logic [LEN_W-1:0]     AVG_LEN_RST   = 5'd16;
   localparam logic [TPS_BITS-1:0]  TICKS_SEC_RST = 20'd1000;
   localparam logic [FREQ_BITS-1:0] LOW_LIM_RST   = 24'd77;
   localparam logic [FREQ_BITS-1:0] HIGH_LIM_RST  = 24'd2560;

   // Channel indexes inside the core.
   localparam logic [1:0] CH_LEFT   = 2'd0;
   localparam logic [1:0] CH_MIDDLE = 2'd1;
   localparam logic [1:0] CH_RIGHT  = 2'd2;

   // Codes on the chosen channel output.
   localparam logic [1:0] SEL_NONE   = 2'd0;
   localparam logic [1:0] SEL_RIGHT  = 2'd1;
   localparam logic [1:0] SEL_LEFT   = 2'd2;
   localparam logic [1:0] SEL_MIDDLE = 2'd3;

   localparam logic [0:0] CMD_TICK  = 1'b0;
   localparam logic [0:0] CMD_QUERY = 1'b1;

   typedef logic [FREQ_BITS-1:0] freq_type;

endpackage

>>> hdl/tpfm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module tpfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tpfm_div.sv
// Bit-serial restoring divider giving a saturated 24-bit quotient.
// Depends on tpfm_pkg for the result width and the saturation value.
module tpfm_div #(
   parameter int NUM_BITS = 33,
   parameter int DEN_BITS = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_BITS-1:0]    num,
   input  logic [DEN_BITS-1:0]    den,
   output logic                   done,
   output tpfm_pkg::freq_type     quot
);

   localparam int QB     = tpfm_pkg::FREQ_BITS;
   localparam int HI_W   = NUM_BITS - QB;
   localparam int CMP_W  = (HI_W > DEN_BITS) ? HI_W : DEN_BITS;
   localparam int CNT_W  = $clog2(QB);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [QB-1:0]       low_ff, low_in;
   logic [QB-1:0]       quot_ff, quot_in;

   logic [CMP_W-1:0]    hi_ext;
   logic [CMP_W-1:0]    den_ext;
   logic [DEN_BITS:0]   trial;
   logic                ge;

   always_comb begin
      hi_ext  = CMP_W'(num[NUM_BITS-1:QB]);
      den_ext = CMP_W'(den);
      trial   = {rem_ff, low_ff[QB-1]};
      ge      = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;

      if (start) begin
         // A quotient that needs more than 24 bits, or a zero divisor, saturates.
         if (den == '0 || hi_ext >= den_ext) begin
            quot_in = tpfm_pkg::FREQ_MAX;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = DEN_BITS'(hi_ext);
            low_in  = num[QB-1:0];
            den_in  = den;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? DEN_BITS'(trial - {1'b0, den_ff}) : DEN_BITS'(trial);
         quot_in = {quot_ff[QB-2:0], ge};
         low_in  = {low_ff[QB-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> hdl/three_channel_pulse_frequency_meter_core.sv
// Top level of the three-channel period-averaging frequency meter.
// Depends on tpfm_pkg, tpfm_ram and tpfm_div.
//
// Usage:
// Each request on the req_ channel is either a timebase tick (req_cmd low)
// carrying one edge flag per channel, or a query (req_cmd high). A tick
// produces no response. A query produces exactly one response on the rsp_
// channel with the three Q16.8 frequencies, the selected one and its code.
// A tick holds req_stall while the channels are visited in turn, with a read
// state for each channel and a write state for each channel that saw an edge,
// because every edge does a read-modify-write of that channel's interval ring
// in the RAM, one channel after another. A query holds req_stall through the
// multiply state, three divisions one after another on the single bit-serial
// divider (a saturating one ends early) and selection, which loads the output register.
// req_stall is high while a request is in work. The response sits in an
// output register; further ticks are taken while it waits on rsp_stall, and
// a following query finishes its divisions and then holds until the
// register is free. Reset clears all sums, counters and ring valid bits at
// once and restores the register defaults; no clearing pass is needed.
// A write of averaging_length clears the rings the same way.
module three_channel_pulse_frequency_meter_core #(
   parameter int MAX_SAMPLES   = tpfm_pkg::MAX_SAMPLES_DEF,
   parameter int INTERVAL_BITS = tpfm_pkg::INTERVAL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cmd,
   input  logic                               req_edge_left,
   input  logic                               req_edge_middle,
   input  logic                               req_edge_right,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_left,
   output logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_middle,
   output logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_right,
   output logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_selected,
   output logic [1:0]                         rsp_chosen_channel,
   input  logic                               csr_wr_en,
   input  logic [tpfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LEN_BITS  = $clog2(MAX_SAMPLES + 1);
   localparam int LCMP_W    = (LEN_BITS > tpfm_pkg::LEN_W) ? LEN_BITS : tpfm_pkg::LEN_W;
   localparam int POS_BITS  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SUM_BITS  = INTERVAL_BITS + $clog2(MAX_SAMPLES);
   localparam int DEPTH     = 3 * MAX_SAMPLES;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int PROD_BITS = LEN_BITS + tpfm_pkg::TPS_BITS;
   localparam int NUM_BITS  = PROD_BITS + tpfm_pkg::FRAC_BITS;
   localparam int FB        = tpfm_pkg::FREQ_BITS;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_TICK_RD  = 3'd1;
   localparam logic [2:0] ST_TICK_WR  = 3'd2;
   localparam logic [2:0] ST_MUL      = 3'd3;
   localparam logic [2:0] ST_DIV_GO   = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT = 3'd5;
   localparam logic [2:0] ST_SEL      = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [1:0]                  ch_ff, ch_in;
   logic [2:0]                  edge_ff, edge_in;

   logic [tpfm_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [tpfm_pkg::TPS_BITS-1:0] tps_ff, tps_in;
   logic [FB-1:0]                 low_ff, low_in;
   logic [FB-1:0]                 high_ff, high_in;

   logic [SUM_BITS-1:0]         sum_ff [3];
   logic [SUM_BITS-1:0]         sum_in [3];
   logic [POS_BITS-1:0]         pos_ff [3];
   logic [POS_BITS-1:0]         pos_in [3];
   logic [INTERVAL_BITS-1:0]    elapsed_ff [3];
   logic [INTERVAL_BITS-1:0]    elapsed_in [3];
   logic [DEPTH-1:0]            valid_ff, valid_in;

   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   tpfm_pkg::freq_type          freq_ff [3];
   tpfm_pkg::freq_type          freq_in [3];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0]               rsp_left_ff, rsp_left_in;
   logic [FB-1:0]               rsp_middle_ff, rsp_middle_in;
   logic [FB-1:0]               rsp_right_ff, rsp_right_in;
   logic [FB-1:0]               rsp_sel_ff, rsp_sel_in;
   logic [1:0]                  rsp_chosen_ff, rsp_chosen_in;

   logic [LEN_BITS-1:0]         eff_len;
   logic [POS_BITS-1:0]         pos_use;
   logic [LEN_BITS-1:0]         pos_inc;
   logic [ADDR_BITS-1:0]        addr;
   logic                        ram_rd_en;
   logic                        ram_wr_en;
   logic [INTERVAL_BITS-1:0]    ram_rd_data;
   logic [INTERVAL_BITS-1:0]    old_interval;
   logic                        div_start;
   logic                        div_done;
   tpfm_pkg::freq_type          div_quot;
   logic                        in_left, in_middle, in_right;
   logic                        accept;

   assign accept = req_valid && !req_stall;

   // Averaging length as used: zero acts as one, oversize values clamp.
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (LCMP_W'(len_ff) > LCMP_W'(MAX_SAMPLES)) begin
         eff_len = LEN_BITS'(MAX_SAMPLES);
      end else begin
         eff_len = LEN_BITS'(len_ff);
      end
   end

   always_comb begin
      pos_use = (LEN_BITS'(pos_ff[ch_ff]) >= eff_len) ? '0 : pos_ff[ch_ff];
      pos_inc = LEN_BITS'(pos_use) + LEN_BITS'(1);
      addr    = ADDR_BITS'(ADDR_BITS'(ch_ff) * ADDR_BITS'(MAX_SAMPLES)
                + ADDR_BITS'(pos_use));
      old_interval = valid_ff[addr] ? ram_rd_data : '0;
   end

   always_comb begin
      in_left   = (freq_ff[tpfm_pkg::CH_LEFT] > low_ff)
                  && (freq_ff[tpfm_pkg::CH_LEFT] < high_ff);
      in_middle = (freq_ff[tpfm_pkg::CH_MIDDLE] > low_ff)
                  && (freq_ff[tpfm_pkg::CH_MIDDLE] < high_ff);
      in_right  = (freq_ff[tpfm_pkg::CH_RIGHT] > low_ff)
                  && (freq_ff[tpfm_pkg::CH_RIGHT] < high_ff);
   end

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      edge_in  = edge_ff;
      len_in   = len_ff;
      tps_in   = tps_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      sum_in     = sum_ff;
      pos_in     = pos_ff;
      elapsed_in = elapsed_ff;
      valid_in   = valid_ff;
      prod_in    = prod_ff;
      freq_in    = freq_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_middle_in = rsp_middle_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_sel_in    = rsp_sel_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in = tpfm_pkg::CH_LEFT;
               if (req_cmd == tpfm_pkg::CMD_QUERY) begin
                  state_in = ST_MUL;
               end else begin
                  // Every channel counts the tick, saturating.
                  for (int c = 0; c < 3; c++) begin
                     if (elapsed_ff[c] != {INTERVAL_BITS{1'b1}}) begin
                        elapsed_in[c] = elapsed_ff[c] + INTERVAL_BITS'(1);
                     end
                  end
                  edge_in  = {req_edge_right, req_edge_middle, req_edge_left};
                  state_in = ST_TICK_RD;
               end
            end
         end
         ST_TICK_RD: begin
            if (edge_ff[ch_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = ST_TICK_WR;
            end else if (ch_ff == tpfm_pkg::CH_RIGHT) begin
               state_in = ST_IDLE;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_TICK_WR: begin
            // The oldest interval leaves the sum and the new one takes its slot.
            ram_wr_en      = 1'b1;
            valid_in[addr] = 1'b1;
            sum_in[ch_ff]  = sum_ff[ch_ff] - SUM_BITS'(old_interval)
                             + SUM_BITS'(elapsed_ff[ch_ff]);
            pos_in[ch_ff]  = (pos_inc >= eff_len) ? '0 : POS_BITS'(pos_inc);
            elapsed_in[ch_ff] = '0;
            if (ch_ff == tpfm_pkg::CH_RIGHT) begin
               state_in = ST_IDLE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_TICK_RD;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(eff_len) * PROD_BITS'(tps_ff);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               freq_in[ch_ff] = div_quot;
               if (ch_ff == tpfm_pkg::CH_RIGHT) begin
                  state_in = ST_SEL;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_SEL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_left_in   = freq_ff[tpfm_pkg::CH_LEFT];
               rsp_middle_in = freq_ff[tpfm_pkg::CH_MIDDLE];
               rsp_right_in  = freq_ff[tpfm_pkg::CH_RIGHT];
               if (in_right) begin
                  rsp_sel_in    = freq_ff[tpfm_pkg::CH_RIGHT];
                  rsp_chosen_in = tpfm_pkg::SEL_RIGHT;
               end else if (in_left) begin
                  rsp_sel_in    = freq_ff[tpfm_pkg::CH_LEFT];
                  rsp_chosen_in = tpfm_pkg::SEL_LEFT;
               end else if (in_middle) begin
                  rsp_sel_in    = freq_ff[tpfm_pkg::CH_MIDDLE];
                  rsp_chosen_in = tpfm_pkg::SEL_MIDDLE;
               end else begin
                  rsp_sel_in    = '0;
                  rsp_chosen_in = tpfm_pkg::SEL_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            tpfm_pkg::CSR_AVG_LEN: begin
               len_in   = csr_wdata[tpfm_pkg::LEN_W-1:0];
               valid_in = '0;
               for (int c = 0; c < 3; c++) begin
                  sum_in[c] = '0;
                  pos_in[c] = '0;
               end
            end
            tpfm_pkg::CSR_TICKS_SEC: tps_in  = csr_wdata[tpfm_pkg::TPS_BITS-1:0];
            tpfm_pkg::CSR_LOW_LIM:   low_in  = csr_wdata[FB-1:0];
            tpfm_pkg::CSR_HIGH_LIM:  high_in = csr_wdata[FB-1:0];
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= tpfm_pkg::CH_LEFT;
         len_ff       <= tpfm_pkg::AVG_LEN_RST;
         tps_ff       <= tpfm_pkg::TICKS_SEC_RST;
         low_ff       <= tpfm_pkg::LOW_LIM_RST;
         high_ff      <= tpfm_pkg::HIGH_LIM_RST;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            sum_ff[c]     <= '0;
            pos_ff[c]     <= '0;
            elapsed_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         len_ff       <= len_in;
         tps_ff       <= tps_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         elapsed_ff   <= elapsed_in;
      end
      edge_ff       <= edge_in;
      prod_ff       <= prod_in;
      freq_ff       <= freq_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_middle_ff <= rsp_middle_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_chosen_ff <= rsp_chosen_in;
   end

   tpfm_ram #(
      .WIDTH (INTERVAL_BITS),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr),
      .wr_data (elapsed_ff[ch_ff]),
      .rd_en   (ram_rd_en),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   tpfm_div #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (SUM_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({prod_ff, {tpfm_pkg::FRAC_BITS{1'b0}}}),
      .den   (sum_ff[ch_ff]),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_freq_left      = rsp_left_ff;
   assign rsp_freq_middle    = rsp_middle_ff;
   assign rsp_freq_right     = rsp_right_ff;
   assign rsp_freq_selected  = rsp_sel_ff;
   assign rsp_chosen_channel = rsp_chosen_ff;

endmodule

>>> hdl/tpfm_checker.sv
// Port-level checker for the frequency meter core, attached by a bind.
// Depends on tpfm_pkg and on the port list of the core.
module tpfm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_left,
   input logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_middle,
   input logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_right,
   input logic [tpfm_pkg::FREQ_BITS-1:0]     rsp_freq_selected,
   input logic [1:0]                         rsp_chosen_channel
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // When no channel is in range the selected frequency reads zero.
   a_sel_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chosen_channel == tpfm_pkg::SEL_NONE
      |-> rsp_freq_selected == '0)
      else $error("selected frequency not zero with no channel chosen");

   // The selected frequency is the one of the chosen channel.
   a_sel_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_chosen_channel == tpfm_pkg::SEL_NONE)
         || (rsp_chosen_channel == tpfm_pkg::SEL_RIGHT
             && rsp_freq_selected == rsp_freq_right)
         || (rsp_chosen_channel == tpfm_pkg::SEL_LEFT
             && rsp_freq_selected == rsp_freq_left)
         || (rsp_chosen_channel == tpfm_pkg::SEL_MIDDLE
             && rsp_freq_selected == rsp_freq_middle))
      else $error("selected frequency differs from the chosen channel");

endmodule

bind three_channel_pulse_frequency_meter_core tpfm_checker u_tpfm_checker (.*);
